/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every rising edge outside reset.
`define SWA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// The expression must never be true at a rising edge outside reset.
`define SWA_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

/* rtl/swa_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swa_pkg
// Types, codes and defaults shared by the window average alarm modules.
// ----------------------------------------------------------------------------
package swa_pkg;

  localparam int MAX_SENSORS_DEF = 16;
  localparam int WINDOW_LEN_DEF  = 5;

  // Slot field of a queued command; wide enough for tables of up to 256 entries.
  localparam int SLOT_W      = 8;
  localparam int QUEUE_DEPTH = 2;

  localparam logic OP_REGISTER = 1'b0;
  localparam logic OP_READING  = 1'b1;

  localparam logic [1:0] EV_HOT   = 2'd0;
  localparam logic [1:0] EV_COLD  = 2'd1;
  localparam logic [1:0] EV_BADID = 2'd2;

  localparam logic CFG_LOW_LIMIT  = 1'b0;
  localparam logic CFG_HIGH_LIMIT = 1'b1;

  localparam logic signed [15:0] LOW_LIMIT_RST  = 16'sd2560;
  localparam logic signed [15:0] HIGH_LIMIT_RST = 16'sd5120;

  typedef struct packed {
    logic               op;
    logic [15:0]        sensor_tag;
    logic signed [15:0] reading;
  } swa_in_t;

  typedef struct packed {
    logic [1:0]         event_res;
    logic [15:0]        event_sensor;
    logic signed [15:0] window_average;
  } swa_out_t;

  typedef enum logic [1:0] {
    CMD_INIT,
    CMD_UPDATE,
    CMD_BADID
  } cmd_kind_t;

  // value is the midpoint for CMD_INIT and the reading for CMD_UPDATE.
  typedef struct packed {
    cmd_kind_t          kind;
    logic [SLOT_W-1:0]  slot;
    logic [15:0]        sensor_tag;
    logic signed [15:0] value;
  } swa_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } swa_q_status_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_SEARCH,
    F_PUSH
  } front_state_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_INIT,
    B_META,
    B_OLD,
    B_CALC,
    B_MUL,
    B_FIN
  } back_state_t;

endpackage

/* rtl/swa_fifo.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// swa_fifo
// Short command queue between the front and the back of the alarm block.
// ----------------------------------------------------------------------------
module swa_fifo import swa_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  swa_cmd_t      push_cmd,
  input  logic          pop,
  output swa_cmd_t      head,
  output swa_q_status_t status
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

  swa_cmd_t         slots_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= push_cmd;
    end
  end

  assign head         = slots_r[rd_ptr_r];
  assign status.full  = (count_r == CNT_FULL);
  assign status.empty = (count_r == '0);

  `SWA_NEVER(a_no_push_full, push && status.full, "command pushed into a full queue")
  `SWA_NEVER(a_no_pop_empty, pop && status.empty, "command popped from an empty queue")

endmodule

/* rtl/swa_front.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// swa_front
// Accepts input words, keeps the id table and makes commands; id 0 readings and full-table registrations make none.
// ----------------------------------------------------------------------------
module swa_front import swa_pkg::*; #(
  parameter int MAX_SENSORS = MAX_SENSORS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  swa_in_t            in_data,
  input  logic signed [15:0] low_limit,
  input  logic signed [15:0] high_limit,
  output logic               q_push,
  output swa_cmd_t           q_cmd,
  input  swa_q_status_t      q_status
);

  localparam int IDX_W = (MAX_SENSORS > 1) ? $clog2(MAX_SENSORS) : 1;
  localparam int CNT_W = $clog2(MAX_SENSORS + 1);
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_SENSORS);

  front_state_t     state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [IDX_W-1:0] scan_r, scan_nxt;
  logic             scan_left_r, scan_left_nxt;
  logic             cmp_vld_r, cmp_vld_nxt;
  logic [IDX_W-1:0] cmp_idx_r, cmp_idx_nxt;
  logic [15:0]      id_r, id_nxt;
  swa_cmd_t         cmd_r, cmd_nxt;

  logic [15:0]      ids_mem [MAX_SENSORS];
  logic [15:0]      ids_q;
  logic             ids_wr, ids_rd;

  logic signed [16:0] lim_sum, lim_adj;
  logic signed [15:0] mid;

  // Midpoint of the limits, truncated toward zero: add one to negative sums before halving.
  assign lim_sum = $signed({low_limit[15], low_limit}) + $signed({high_limit[15], high_limit});
  assign lim_adj = lim_sum + $signed({16'd0, lim_sum[16]});
  assign mid     = lim_adj[16:1];

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    scan_nxt      = scan_r;
    scan_left_nxt = scan_left_r;
    cmp_vld_nxt   = 1'b0;
    cmp_idx_nxt   = cmp_idx_r;
    id_nxt        = id_r;
    cmd_nxt       = cmd_r;
    ids_wr        = 1'b0;
    ids_rd        = 1'b0;
    q_push        = 1'b0;
    in_stall      = (state_r != F_IDLE);
    unique case (state_r)
      F_IDLE: begin
        if (in_valid) begin
          if (in_data.op == OP_REGISTER) begin
            if (count_r < MAX_CNT) begin
              ids_wr             = 1'b1;
              count_nxt          = count_r + 1'b1;
              cmd_nxt.kind       = CMD_INIT;
              cmd_nxt.slot       = SLOT_W'(count_r[IDX_W-1:0]);
              cmd_nxt.sensor_tag = in_data.sensor_tag;
              cmd_nxt.value      = mid;
              state_nxt          = F_PUSH;
            end
          end else if (in_data.sensor_tag != '0) begin
            id_nxt             = in_data.sensor_tag;
            cmd_nxt.slot       = '0;
            cmd_nxt.sensor_tag = in_data.sensor_tag;
            cmd_nxt.value      = in_data.reading;
            if (count_r == '0) begin
              cmd_nxt.kind = CMD_BADID;
              state_nxt    = F_PUSH;
            end else begin
              cmd_nxt.kind  = CMD_UPDATE;
              scan_nxt      = IDX_W'(count_r - 1'b1);
              scan_left_nxt = 1'b1;
              state_nxt     = F_SEARCH;
            end
          end
        end
      end
      F_SEARCH: begin
        // Reads run newest entry first, one a cycle; each compare uses the registered read result.
        ids_rd = scan_left_r;
        if (scan_left_r) begin
          cmp_vld_nxt   = 1'b1;
          cmp_idx_nxt   = scan_r;
          scan_left_nxt = (scan_r != '0);
          scan_nxt      = scan_r - 1'b1;
        end
        if (cmp_vld_r && (ids_q == id_r)) begin
          cmd_nxt.slot  = SLOT_W'(cmp_idx_r);
          cmp_vld_nxt   = 1'b0;
          scan_left_nxt = 1'b0;
          state_nxt     = F_PUSH;
        end else if (!scan_left_r) begin
          cmd_nxt.kind = CMD_BADID;
          state_nxt    = F_PUSH;
        end
      end
      F_PUSH: begin
        if (!q_status.full) begin
          q_push    = 1'b1;
          state_nxt = F_IDLE;
        end
      end
      default: begin
        state_nxt = F_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= F_IDLE;
      count_r     <= '0;
      scan_left_r <= 1'b0;
      cmp_vld_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      scan_left_r <= scan_left_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    scan_r    <= scan_nxt;
    cmp_idx_r <= cmp_idx_nxt;
    id_r      <= id_nxt;
    cmd_r     <= cmd_nxt;
  end

  always_ff @(posedge clk) begin
    if (ids_wr) begin
      ids_mem[count_r[IDX_W-1:0]] <= in_data.sensor_tag;
    end
    if (ids_rd) begin
      ids_q <= ids_mem[scan_r];
    end
  end

  assign q_cmd = cmd_r;

  `SWA_NEVER(a_count_bound, count_r > MAX_CNT, "id table count beyond capacity")
  `SWA_ASSERT(a_cmp_in_table, cmp_vld_r |-> (CNT_W'(cmp_idx_r) < count_r),
              "search compared an entry that was never registered")

endmodule

/* rtl/swa_back.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// swa_back
// Executes queued commands: window fill, window update, average, alarm, unknown id.
// ----------------------------------------------------------------------------
module swa_back import swa_pkg::*; #(
  parameter int MAX_SENSORS = MAX_SENSORS_DEF,
  parameter int WINDOW_LEN  = WINDOW_LEN_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  swa_cmd_t           q_head,
  input  swa_q_status_t      q_status,
  output logic               q_pop,
  input  logic signed [15:0] low_limit,
  input  logic signed [15:0] high_limit,
  output logic               out_valid,
  input  logic               out_stall,
  output swa_out_t           out_data
);

  localparam int IDX_W     = (MAX_SENSORS > 1) ? $clog2(MAX_SENSORS) : 1;
  localparam int PTR_W     = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
  localparam int SUM_W     = 16 + $clog2(WINDOW_LEN);
  localparam int DIV_L     = $clog2(WINDOW_LEN);
  localparam int DIV_K     = SUM_W + DIV_L;
  localparam int PROD_W    = SUM_W + DIV_K + 1;
  localparam int WIN_DEPTH = MAX_SENSORS * WINDOW_LEN;
  localparam int WIN_AW    = (WIN_DEPTH > 1) ? $clog2(WIN_DEPTH) : 1;
  localparam int META_W    = PTR_W + SUM_W;

  // ceil(2^K / WINDOW_LEN); with K = SUM_W + log2 the product is exact for any sum.
  localparam logic [DIV_K:0] RECIP =
    (DIV_K+1)'(((64'd1 << DIV_K) + 64'(WINDOW_LEN) - 64'd1) / 64'(WINDOW_LEN));
  localparam logic [PTR_W-1:0]        PTR_LAST = PTR_W'(WINDOW_LEN - 1);
  localparam logic signed [SUM_W-1:0] WIN_S    = SUM_W'(WINDOW_LEN);
  localparam logic [WIN_AW-1:0]       WIN_A    = WIN_AW'(WINDOW_LEN);

  back_state_t              state_r, state_nxt;
  swa_cmd_t                 cmd_r, cmd_nxt;
  logic [WIN_AW-1:0]        base_r, base_nxt;
  logic [WIN_AW-1:0]        win_addr_r, win_addr_nxt;
  logic [PTR_W-1:0]         fill_r, fill_nxt;
  logic [PTR_W-1:0]         ptr_r, ptr_nxt;
  logic signed [SUM_W-1:0]  sum_r, sum_nxt;
  logic                     neg_r, neg_nxt;
  logic [SUM_W-1:0]         mag_r, mag_nxt;
  logic [PROD_W-1:0]        prod_r, prod_nxt;
  logic                     out_valid_r, out_valid_nxt;
  swa_out_t                 out_data_r, out_data_nxt;

  logic [15:0]              win_mem [WIN_DEPTH];
  logic [META_W-1:0]        meta_mem [MAX_SENSORS];
  logic signed [15:0]       win_q;
  logic [META_W-1:0]        meta_q;
  logic                     win_we, win_re, meta_we, meta_re;
  logic [WIN_AW-1:0]        win_wa, win_ra;
  logic [15:0]              win_wd;
  logic [META_W-1:0]        meta_wd;
  logic [IDX_W-1:0]         slot_idx;

  logic signed [SUM_W-1:0]  val_ext, init_sum, new_sum;
  logic [PTR_W-1:0]         ptr_inc;
  logic [SUM_W-1:0]         quot;
  logic signed [SUM_W:0]    avg_full;
  logic signed [15:0]       avg;
  logic                     out_free;

  assign slot_idx = cmd_r.slot[IDX_W-1:0];
  assign val_ext  = SUM_W'(cmd_r.value);
  assign init_sum = val_ext * WIN_S;
  assign new_sum  = sum_r - SUM_W'(win_q) + val_ext;
  assign ptr_inc  = (ptr_r == PTR_LAST) ? '0 : ptr_r + 1'b1;
  assign quot     = prod_r[DIV_K +: SUM_W];
  assign avg_full = neg_r ? -$signed({1'b0, quot}) : $signed({1'b0, quot});
  assign avg      = avg_full[15:0];
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    base_nxt      = base_r;
    win_addr_nxt  = win_addr_r;
    fill_nxt      = fill_r;
    ptr_nxt       = ptr_r;
    sum_nxt       = sum_r;
    neg_nxt       = neg_r;
    mag_nxt       = mag_r;
    prod_nxt      = prod_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    q_pop         = 1'b0;
    win_we        = 1'b0;
    win_re        = 1'b0;
    meta_we       = 1'b0;
    meta_re       = 1'b0;
    win_wa        = win_addr_r;
    win_ra        = win_addr_r;
    win_wd        = cmd_r.value;
    meta_wd       = {ptr_inc, new_sum};
    unique case (state_r)
      B_IDLE: begin
        if (!q_status.empty) begin
          q_pop    = 1'b1;
          cmd_nxt  = q_head;
          base_nxt = WIN_AW'(WIN_AW'(q_head.slot[IDX_W-1:0]) * WIN_A);
          fill_nxt = '0;
          unique case (q_head.kind)
            CMD_INIT:   state_nxt = B_INIT;
            CMD_UPDATE: state_nxt = B_META;
            CMD_BADID:  state_nxt = B_FIN;
            default:    state_nxt = B_IDLE;
          endcase
        end
      end
      B_INIT: begin
        // One window word a cycle; the running sum starts at midpoint times length.
        win_we = 1'b1;
        win_wa = base_r + WIN_AW'(fill_r);
        if (fill_r == '0) begin
          meta_we = 1'b1;
          meta_wd = {{PTR_W{1'b0}}, init_sum};
        end
        if (fill_r == PTR_LAST) begin
          state_nxt = B_IDLE;
        end else begin
          fill_nxt = fill_r + 1'b1;
        end
      end
      B_META: begin
        meta_re   = 1'b1;
        state_nxt = B_OLD;
      end
      B_OLD: begin
        ptr_nxt      = meta_q[META_W-1 -: PTR_W];
        sum_nxt      = $signed(meta_q[SUM_W-1:0]);
        win_addr_nxt = base_r + WIN_AW'(meta_q[META_W-1 -: PTR_W]);
        win_re       = 1'b1;
        win_ra       = win_addr_nxt;
        state_nxt    = B_CALC;
      end
      B_CALC: begin
        // The oldest word is replaced by the reading and the sum follows it.
        win_we    = 1'b1;
        meta_we   = 1'b1;
        neg_nxt   = new_sum[SUM_W-1];
        mag_nxt   = new_sum[SUM_W-1] ? SUM_W'(-new_sum) : SUM_W'(new_sum);
        state_nxt = B_MUL;
      end
      B_MUL: begin
        prod_nxt  = mag_r * RECIP;
        state_nxt = B_FIN;
      end
      B_FIN: begin
        if (cmd_r.kind == CMD_BADID) begin
          if (out_free) begin
            out_valid_nxt               = 1'b1;
            out_data_nxt.event_res      = EV_BADID;
            out_data_nxt.event_sensor   = cmd_r.sensor_tag;
            out_data_nxt.window_average = '0;
            state_nxt                   = B_IDLE;
          end
        end else if (avg > high_limit) begin
          if (out_free) begin
            out_valid_nxt               = 1'b1;
            out_data_nxt.event_res      = EV_HOT;
            out_data_nxt.event_sensor   = cmd_r.sensor_tag;
            out_data_nxt.window_average = avg;
            state_nxt                   = B_IDLE;
          end
        end else if (avg < low_limit) begin
          if (out_free) begin
            out_valid_nxt               = 1'b1;
            out_data_nxt.event_res      = EV_COLD;
            out_data_nxt.event_sensor   = cmd_r.sensor_tag;
            out_data_nxt.window_average = avg;
            state_nxt                   = B_IDLE;
          end
        end else begin
          state_nxt = B_IDLE;
        end
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    base_r     <= base_nxt;
    win_addr_r <= win_addr_nxt;
    fill_r     <= fill_nxt;
    ptr_r      <= ptr_nxt;
    sum_r      <= sum_nxt;
    neg_r      <= neg_nxt;
    mag_r      <= mag_nxt;
    prod_r     <= prod_nxt;
    out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (win_we) begin
      win_mem[win_wa] <= win_wd;
    end
    if (win_re) begin
      win_q <= win_mem[win_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (meta_we) begin
      meta_mem[slot_idx] <= meta_wd;
    end
    if (meta_re) begin
      meta_q <= meta_mem[slot_idx];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `SWA_ASSERT(a_badid_zero,
              (out_valid_r && (out_data_r.event_res == EV_BADID)) |->
                (out_data_r.window_average == '0),
              "unknown id event carries a nonzero average")
  `SWA_NEVER(a_event_code,
             out_valid_r && (out_data_r.event_res != EV_HOT) &&
               (out_data_r.event_res != EV_COLD) && (out_data_r.event_res != EV_BADID),
             "result word carries an undefined event code")

endmodule

/* rtl/sensor_window_average_alarm.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sensor_window_average_alarm
// Per-sensor moving average over a window of readings with a range alarm.
// ----------------------------------------------------------------------------
// Input words (in_valid/in_stall) either register a sensor id or carry a
// reading; a word moves when valid is high and stall is low. Result words
// (out_valid/out_stall) report too hot, too cold or an unknown id. The two
// limits are written through cfg_valid/cfg_ready with cfg_index 0 for the
// low limit and 1 for the high limit; cfg_ready is always high.
// A front stage takes one word at a time and searches the id table, one
// entry a cycle from the newest, holding the input stalled until the
// word's command enters the queue. A queue of two commands feeds the
// back stage, which fills a new window word by word and handles a reading
// in steps: command pop, table read, window read-modify-write, reciprocal
// multiply, compare. When the receiver stalls, the result stays in the
// output register, the back stage waits on its next result and the queue
// and then the input back up. Reset empties the id table and the queue and
// restores the default limits; window contents are defined once an id is
// registered.
// ----------------------------------------------------------------------------
module sensor_window_average_alarm import swa_pkg::*; #(
  parameter int MAX_SENSORS = MAX_SENSORS_DEF,
  parameter int WINDOW_LEN  = WINDOW_LEN_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  swa_in_t     in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output swa_out_t    out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);

  logic signed [15:0] low_limit_r, low_limit_nxt;
  logic signed [15:0] high_limit_r, high_limit_nxt;

  logic          q_push, q_pop;
  swa_cmd_t      q_cmd, q_head;
  swa_q_status_t q_status;

  assign cfg_ready = 1'b1;

  always_comb begin
    low_limit_nxt  = low_limit_r;
    high_limit_nxt = high_limit_r;
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_LOW_LIMIT:  low_limit_nxt  = $signed(cfg_data);
        CFG_HIGH_LIMIT: high_limit_nxt = $signed(cfg_data);
        default:        low_limit_nxt  = low_limit_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_limit_r  <= LOW_LIMIT_RST;
      high_limit_r <= HIGH_LIMIT_RST;
    end else begin
      low_limit_r  <= low_limit_nxt;
      high_limit_r <= high_limit_nxt;
    end
  end

  swa_front #(
    .MAX_SENSORS (MAX_SENSORS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .low_limit  (low_limit_r),
    .high_limit (high_limit_r),
    .q_push     (q_push),
    .q_cmd      (q_cmd),
    .q_status   (q_status)
  );

  swa_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_cmd),
    .pop      (q_pop),
    .head     (q_head),
    .status   (q_status)
  );

  swa_back #(
    .MAX_SENSORS (MAX_SENSORS),
    .WINDOW_LEN  (WINDOW_LEN)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_head     (q_head),
    .q_status   (q_status),
    .q_pop      (q_pop),
    .low_limit  (low_limit_r),
    .high_limit (high_limit_r),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

endmodule
